@@ rtl/msc_pkg.sv @@
// Marching squares cell package: widths, pipeline types and the segment plan table.
// No dependencies; every rtl module imports it.
package msc_pkg;

  localparam int unsigned ELEV_W     = 24;
  localparam int unsigned DIFF_W     = 26;
  localparam int unsigned DIV_W      = 25;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned ID_W       = 25;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned GW_W       = 13;
  localparam int unsigned QBITS      = 16;
  localparam int unsigned DIV_STAGES = QBITS + 1;

  localparam logic [GW_W-1:0]   GRID_WIDTH_RST = 13'd4096;
  localparam logic [FRAC_W-1:0] FRAC_ONE       = 17'd65536;
  localparam logic [FRAC_W-1:0] FRAC_ZERO      = 17'd0;

  typedef enum logic [1:0] {
    SIDE_S = 2'd0,
    SIDE_N = 2'd1,
    SIDE_W = 2'd2,
    SIDE_E = 2'd3
  } side_e;

  typedef struct packed {
    logic [DIV_W-1:0] dvsr;
    logic [DIV_W-1:0] rem;
    logic [QBITS-1:0] quo;
  } div_t;

  typedef struct packed {
    logic                 skip;
    logic [3:0]           code;
    logic                 centre;
    logic [3:0][ID_W-1:0] id;
    logic [3:0]           zero;
    logic [3:0]           one;
  } cell_t;

  typedef struct packed {
    logic [1:0] nseg;
    side_e      a0;
    side_e      b0;
    side_e      a1;
    side_e      b1;
  } plan_t;

  function automatic plan_t seg_plan(input logic [3:0] code, input logic centre);
    plan_t p;
    p = '{nseg: 2'd0, a0: SIDE_S, b0: SIDE_W, a1: SIDE_E, b1: SIDE_N};
    case (code) inside
      4'd1, 4'd14: begin p.nseg = 2'd1; p.a0 = SIDE_S; p.b0 = SIDE_W; end
      4'd2, 4'd13: begin p.nseg = 2'd1; p.a0 = SIDE_S; p.b0 = SIDE_E; end
      4'd3, 4'd12: begin p.nseg = 2'd1; p.a0 = SIDE_W; p.b0 = SIDE_E; end
      4'd4, 4'd11: begin p.nseg = 2'd1; p.a0 = SIDE_E; p.b0 = SIDE_N; end
      4'd6, 4'd9:  begin p.nseg = 2'd1; p.a0 = SIDE_S; p.b0 = SIDE_N; end
      4'd7, 4'd8:  begin p.nseg = 2'd1; p.a0 = SIDE_W; p.b0 = SIDE_N; end
      4'd5, 4'd10: begin
        p.nseg = 2'd2;
        if ((code == 4'd5) == centre) begin
          p.a0 = SIDE_S; p.b0 = SIDE_E; p.a1 = SIDE_W; p.b1 = SIDE_N;
        end else begin
          p.a0 = SIDE_S; p.b0 = SIDE_W; p.a1 = SIDE_E; p.b1 = SIDE_N;
        end
      end
      default: p.nseg = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/msc_front.sv @@
// Front stages: input capture, edge differences, sign fix, corner code and edge ids.
// Depends on msc_pkg.
module msc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_sw_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_se_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_ne_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_nw_i,
  input  logic                       cell_void_i,
  input  logic [msc_pkg::ELEV_W-1:0] contour_level_i,
  input  logic [msc_pkg::POS_W-1:0]  cell_row_i,
  input  logic [msc_pkg::POS_W-1:0]  cell_col_i,
  input  logic [msc_pkg::GW_W-1:0]   grid_width_i,
  output logic                       valid_o,
  output msc_pkg::cell_t             cell_o,
  output msc_pkg::div_t [3:0]        div_o
);
  import msc_pkg::*;

  // stage 0: captured transaction
  logic                          v0_q;
  logic signed [ELEV_W-1:0]      cn0_q [4];
  logic                          void0_q;
  logic signed [ELEV_W-1:0]      lvl0_q;
  logic [POS_W-1:0]              row0_q, col0_q;

  // stage 1
  logic                          v1_q;
  logic signed [DIFF_W-1:0]      d1_q [4];
  logic signed [DIFF_W-1:0]      n1_q [4];
  logic signed [DIFF_W-1:0]      d1_d [4];
  logic signed [DIFF_W-1:0]      n1_d [4];
  logic [3:0]                    code1_q, code1_d;
  logic signed [DIFF_W-1:0]      sum1_q;
  logic signed [ELEV_W-1:0]      lvl1_q;
  logic [ID_W-1:0]               base1_q;
  logic [POS_W-1:0]              col1_q;
  logic                          void1_q;

  // stage 2
  logic                          v2_q;
  cell_t                         cell2_q, cell2_d;
  div_t [3:0]                    div2_q, div2_d;

  localparam logic [1:0] LO_IDX [4] = '{2'd0, 2'd3, 2'd0, 2'd1};
  localparam logic [1:0] HI_IDX [4] = '{2'd1, 2'd2, 2'd3, 2'd2};

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      d1_d[s] = DIFF_W'(cn0_q[HI_IDX[s]]) - DIFF_W'(cn0_q[LO_IDX[s]]);
      n1_d[s] = DIFF_W'(lvl0_q) - DIFF_W'(cn0_q[LO_IDX[s]]);
      code1_d[s] = cn0_q[s] > lvl0_q;
    end
  end

  always_comb begin
    logic signed [DIFF_W-1:0] dd, nn;
    logic [ID_W-1:0]          p, pw, p1;
    cell2_d = '0;
    p  = base1_q + ID_W'(col1_q);
    pw = p + ID_W'(grid_width_i);
    p1 = p + ID_W'(1);
    cell2_d.skip   = void1_q;
    cell2_d.code   = code1_q;
    cell2_d.centre = sum1_q > signed'({lvl1_q, 2'b00});
    cell2_d.id[SIDE_S] = {p[ID_W-2:0], 1'b0};
    cell2_d.id[SIDE_W] = {p[ID_W-2:0], 1'b1};
    cell2_d.id[SIDE_N] = {pw[ID_W-2:0], 1'b0};
    cell2_d.id[SIDE_E] = {p1[ID_W-2:0], 1'b1};
    for (int s = 0; s < 4; s++) begin
      // flip both so the span is positive
      dd = d1_q[s][DIFF_W-1] ? -d1_q[s] : d1_q[s];
      nn = d1_q[s][DIFF_W-1] ? -n1_q[s] : n1_q[s];
      cell2_d.zero[s] = (d1_q[s] == '0) || (nn <= 0);
      cell2_d.one[s]  = nn >= dd;
      div2_d[s].dvsr  = dd[DIV_W-1:0];
      div2_d[s].rem   = nn[DIV_W-1:0];
      div2_d[s].quo   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= take_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      cn0_q[0] <= corner_sw_i;
      cn0_q[1] <= corner_se_i;
      cn0_q[2] <= corner_ne_i;
      cn0_q[3] <= corner_nw_i;
      void0_q  <= cell_void_i;
      lvl0_q   <= contour_level_i;
      row0_q   <= cell_row_i;
      col0_q   <= cell_col_i;
    end
    d1_q    <= d1_d;
    n1_q    <= n1_d;
    code1_q <= code1_d;
    sum1_q  <= DIFF_W'(cn0_q[0]) + DIFF_W'(cn0_q[1]) + DIFF_W'(cn0_q[2])
             + DIFF_W'(cn0_q[3]);
    lvl1_q  <= lvl0_q;
    base1_q <= ID_W'(row0_q) * ID_W'(grid_width_i);
    col1_q  <= col0_q;
    void1_q <= void0_q;
    cell2_q <= cell2_d;
    div2_q  <= div2_d;
  end

  assign valid_o = v2_q;
  assign cell_o  = cell2_q;
  assign div_o   = div2_q;

endmodule

@@ rtl/msc_div.sv @@
// Pipelined fraction divider: one quotient bit per stage, then round half up.
// Depends on msc_pkg.
module msc_div (
  input  logic                       clk_i,
  input  msc_pkg::div_t              op_i,
  output logic [msc_pkg::FRAC_W-1:0] quo_o
);
  import msc_pkg::*;

  div_t             stage_q [QBITS];
  div_t             stage_d [QBITS];
  logic [FRAC_W-1:0] quo_q;

  function automatic div_t div_step(input div_t x);
    div_t             y;
    logic [DIV_W:0]   t;
    logic             ge;
    t      = {x.rem, 1'b0};
    ge     = t >= {1'b0, x.dvsr};
    y.dvsr = x.dvsr;
    y.rem  = ge ? DIV_W'(t - {1'b0, x.dvsr}) : t[DIV_W-1:0];
    y.quo  = {x.quo[QBITS-2:0], ge};
    return y;
  endfunction

  always_comb begin
    stage_d[0] = div_step(op_i);
    for (int k = 1; k < QBITS; k++) begin
      stage_d[k] = div_step(stage_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DIV_W:0] s;
    s = {1'b0, stage_q[QBITS-1].rem} + {2'b00, stage_q[QBITS-1].dvsr[DIV_W-1:1]};
    for (int k = 0; k < QBITS; k++) begin
      stage_q[k] <= stage_d[k];
    end
    quo_q <= {1'b0, stage_q[QBITS-1].quo}
           + FRAC_W'(s >= {1'b0, stage_q[QBITS-1].dvsr});
  end

  assign quo_o = quo_q;

endmodule

@@ rtl/msc_emit.sv @@
// Segment selection and result sequencing; a saddle's second segment follows in the next cycle.
// Depends on msc_pkg.
module msc_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  msc_pkg::cell_t               cell_i,
  input  logic [3:0][msc_pkg::FRAC_W-1:0] quo_i,
  output logic                         seg_valid_o,
  output logic [msc_pkg::ID_W-1:0]     edge_first_o,
  output logic [msc_pkg::FRAC_W-1:0]   frac_first_o,
  output logic [msc_pkg::ID_W-1:0]     edge_second_o,
  output logic [msc_pkg::FRAC_W-1:0]   frac_second_o,
  output logic                         last_segment_o
);
  import msc_pkg::*;

  logic [3:0][FRAC_W-1:0] fr;
  plan_t                  plan;
  logic                   emit, pend_d;
  logic                   out_v_q, pend_q, last_q;
  logic [ID_W-1:0]        e1_q, e2_q, pe1_q, pe2_q;
  logic [FRAC_W-1:0]      f1_q, f2_q, pf1_q, pf2_q;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      fr[s] = cell_i.zero[s] ? FRAC_ZERO : (cell_i.one[s] ? FRAC_ONE : quo_i[s]);
    end
    plan   = seg_plan(cell_i.code, cell_i.centre);
    emit   = valid_i && !cell_i.skip && (plan.nseg != 2'd0);
    pend_d = emit && (plan.nseg == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      out_v_q <= emit || pend_q;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      e1_q   <= cell_i.id[plan.a0];
      f1_q   <= fr[plan.a0];
      e2_q   <= cell_i.id[plan.b0];
      f2_q   <= fr[plan.b0];
      last_q <= plan.nseg == 2'd1;
      pe1_q  <= cell_i.id[plan.a1];
      pf1_q  <= fr[plan.a1];
      pe2_q  <= cell_i.id[plan.b1];
      pf2_q  <= fr[plan.b1];
    end else if (pend_q) begin
      // advance the held second segment
      e1_q   <= pe1_q;
      f1_q   <= pf1_q;
      e2_q   <= pe2_q;
      f2_q   <= pf2_q;
      last_q <= 1'b1;
    end
  end

  assign seg_valid_o    = out_v_q;
  assign edge_first_o   = e1_q;
  assign frac_first_o   = f1_q;
  assign edge_second_o  = e2_q;
  assign frac_second_o  = f2_q;
  assign last_segment_o = last_q;

endmodule

@@ rtl/marching_squares_cell_core.sv @@
// Marching squares isoline cell, top level: config register, front, four dividers, emit.
// Depends on msc_pkg, msc_front, msc_div and msc_emit.
//
//  channel   handshake                    payload
//  input     start / busy                 corners, void, level, row, col
//  config    cfg_valid / cfg_ready        cfg_data_i (grid width)
//  result    seg_valid_o (strobe)         edge/frac first and second, last_segment
//
// A cell is never taken while busy is high: busy is high in the cycle after
// an accept only, leaving the slot a saddle needs for its second segment.
// The first result reaches the ports through 3 front stages (the first loaded at the
// accepting edge), 17 divider stages and the output register; a saddle's second
// segment follows in the next cycle.
// Reset clears the valid, busy and pending bits only and loads grid width 4096; no clearing pass is needed.
// Results are never held off; nothing in the pipeline stalls.
module marching_squares_cell_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [msc_pkg::ELEV_W-1:0] corner_sw_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_se_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_ne_i,
  input  logic [msc_pkg::ELEV_W-1:0] corner_nw_i,
  input  logic                       cell_void_i,
  input  logic [msc_pkg::ELEV_W-1:0] contour_level_i,
  input  logic [msc_pkg::POS_W-1:0]  cell_row_i,
  input  logic [msc_pkg::POS_W-1:0]  cell_col_i,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [msc_pkg::GW_W-1:0]   cfg_data_i,
  output logic                       seg_valid_o,
  output logic [msc_pkg::ID_W-1:0]   edge_first_o,
  output logic [msc_pkg::FRAC_W-1:0] frac_first_o,
  output logic [msc_pkg::ID_W-1:0]   edge_second_o,
  output logic [msc_pkg::FRAC_W-1:0] frac_second_o,
  output logic                       last_segment_o
);
  import msc_pkg::*;

  logic                   take, busy_q;
  logic [GW_W-1:0]        grid_width_q;
  logic                   fv;
  cell_t                  fcell;
  div_t [3:0]             fdiv;
  logic [3:0][FRAC_W-1:0] quo;
  logic                   mv_q [DIV_STAGES];
  cell_t                  mc_q [DIV_STAGES];

  assign take      = start && !busy_q;
  assign busy      = busy_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      grid_width_q <= GRID_WIDTH_RST;
    end else begin
      busy_q <= take;
      if (cfg_valid) begin
        grid_width_q <= cfg_data_i;
      end
    end
  end

  msc_front u_front (
    .clk_i, .rst_ni,
    .take_i          (take),
    .corner_sw_i, .corner_se_i, .corner_ne_i, .corner_nw_i,
    .cell_void_i, .contour_level_i, .cell_row_i, .cell_col_i,
    .grid_width_i    (grid_width_q),
    .valid_o         (fv),
    .cell_o          (fcell),
    .div_o           (fdiv)
  );

  for (genvar s = 0; s < 4; s++) begin : g_div
    msc_div u_div (
      .clk_i,
      .op_i  (fdiv[s]),
      .quo_o (quo[s])
    );
  end

  // hold cell info alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) mv_q[k] <= 1'b0;
    end else begin
      mv_q[0] <= fv;
      for (int k = 1; k < DIV_STAGES; k++) mv_q[k] <= mv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q[0] <= fcell;
    for (int k = 1; k < DIV_STAGES; k++) mc_q[k] <= mc_q[k-1];
  end

  msc_emit u_emit (
    .clk_i, .rst_ni,
    .valid_i        (mv_q[DIV_STAGES-1]),
    .cell_i         (mc_q[DIV_STAGES-1]),
    .quo_i          (quo),
    .seg_valid_o, .edge_first_o, .frac_first_o,
    .edge_second_o, .frac_second_o, .last_segment_o
  );

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> busy) else $error("accept not followed by busy");

  a_pair_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_valid_o && !last_segment_o) |=> (seg_valid_o && last_segment_o))
    else $error("first saddle segment not followed by last");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_o |-> (frac_first_o <= FRAC_ONE && frac_second_o <= FRAC_ONE))
    else $error("fraction above one");

  a_no_stacked_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q[DIV_STAGES-1] |=> !mv_q[DIV_STAGES-1])
    else $error("cells closer than two cycles");

endmodule

@@ tb/sv/marching_squares_cell_core_tb.sv @@
// Testbench for marching_squares_cell_core: directed and random cells checked against
// an in-bench predictor of the corner code, saddle pairing, edge ids and fractions.
// Depends on msc_pkg and the marching_squares_cell_core RTL.
module marching_squares_cell_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [ID_W-1:0]   edge_a;
    logic [FRAC_W-1:0] frac_a;
    logic [ID_W-1:0]   edge_b;
    logic [FRAC_W-1:0] frac_b;
    logic              last;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ELEV_W-1:0] corner_sw_i = '0, corner_se_i = '0, corner_ne_i = '0, corner_nw_i = '0;
  logic cell_void_i = 1'b0;
  logic [ELEV_W-1:0] contour_level_i = '0;
  logic [POS_W-1:0] cell_row_i = '0, cell_col_i = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GW_W-1:0] cfg_data_i = '0;
  logic seg_valid_o;
  logic [ID_W-1:0] edge_first_o, edge_second_o;
  logic [FRAC_W-1:0] frac_first_o, frac_second_o;
  logic last_segment_o;

  segment_t    seg_expected[$];
  logic [GW_W-1:0] width_model = GRID_WIDTH_RST;
  int unsigned idle_pct = 0;
  int unsigned cycle_cnt = 0;
  bit          failed = 1'b0;

  marching_squares_cell_core DUT (
    .clk_i, .rst_ni, .start, .busy,
    .corner_sw_i, .corner_se_i, .corner_ne_i, .corner_nw_i,
    .cell_void_i, .contour_level_i, .cell_row_i, .cell_col_i,
    .cfg_valid, .cfg_ready, .cfg_data_i,
    .seg_valid_o, .edge_first_o, .frac_first_o, .edge_second_o, .frac_second_o,
    .last_segment_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [FRAC_W-1:0] crossing(longint lo, longint hi, longint lvl);
    longint d, n;
    d = hi - lo;
    n = lvl - lo;
    if (d == 0) return FRAC_ZERO;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    if (n <= 0) return FRAC_ZERO;
    if (n >= d) return FRAC_ONE;
    return FRAC_W'((n * 65536 + d / 2) / d);
  endfunction

  function automatic logic [ID_W-1:0] lattice_id(longint r, longint c, int kind);
    longint v;
    v = (r * longint'(width_model) + c) * 2 + kind;
    return v[ID_W-1:0];
  endfunction

  task automatic side_of(side_e s, longint cn[4], longint lvl, longint r, longint c,
                         output logic [ID_W-1:0] id, output logic [FRAC_W-1:0] fr);
    case (s)
      SIDE_S: begin id = lattice_id(r, c, 0); fr = crossing(cn[0], cn[1], lvl); end
      SIDE_N: begin id = lattice_id(r + 1, c, 0); fr = crossing(cn[3], cn[2], lvl); end
      SIDE_W: begin id = lattice_id(r, c, 1); fr = crossing(cn[0], cn[3], lvl); end
      default: begin id = lattice_id(r, c + 1, 1); fr = crossing(cn[1], cn[2], lvl); end
    endcase
  endtask

  task automatic predict_segments(logic [ELEV_W-1:0] sw, se, ne, nw, logic vd,
                                  logic [ELEV_W-1:0] lv, logic [POS_W-1:0] r, c);
    longint cn[4];
    longint lvl;
    logic [3:0] code;
    bit above;
    int nseg;
    side_e pa[2], pb[2];
    segment_t sg;
    cn[0] = longint'(signed'(sw));
    cn[1] = longint'(signed'(se));
    cn[2] = longint'(signed'(ne));
    cn[3] = longint'(signed'(nw));
    lvl = longint'(signed'(lv));
    if (vd) return;
    code = {cn[3] > lvl, cn[2] > lvl, cn[1] > lvl, cn[0] > lvl};
    above = (cn[0] + cn[1] + cn[2] + cn[3]) > 4 * lvl;
    nseg = 1;
    case (code)
      4'd1, 4'd14: begin pa[0] = SIDE_S; pb[0] = SIDE_W; end
      4'd2, 4'd13: begin pa[0] = SIDE_S; pb[0] = SIDE_E; end
      4'd3, 4'd12: begin pa[0] = SIDE_W; pb[0] = SIDE_E; end
      4'd4, 4'd11: begin pa[0] = SIDE_E; pb[0] = SIDE_N; end
      4'd6, 4'd9:  begin pa[0] = SIDE_S; pb[0] = SIDE_N; end
      4'd7, 4'd8:  begin pa[0] = SIDE_W; pb[0] = SIDE_N; end
      4'd5, 4'd10: begin
        nseg = 2;
        if ((code == 4'd5) == above) begin
          pa[0] = SIDE_S; pb[0] = SIDE_E; pa[1] = SIDE_W; pb[1] = SIDE_N;
        end else begin
          pa[0] = SIDE_S; pb[0] = SIDE_W; pa[1] = SIDE_E; pb[1] = SIDE_N;
        end
      end
      default: nseg = 0;
    endcase
    for (int k = 0; k < nseg; k++) begin
      side_of(pa[k], cn, lvl, r, c, sg.edge_a, sg.frac_a);
      side_of(pb[k], cn, lvl, r, c, sg.edge_b, sg.frac_b);
      sg.last = (k == nseg - 1);
      seg_expected.insert(seg_expected.size(), sg);
    end
  endtask

  // Check every strobed segment against the oldest prediction.
  always @(posedge clk_i) begin
    segment_t e;
    if (rst_ni && seg_valid_o) begin
      if (seg_expected.size() == 0) begin
        $display("%0t unexpected segment edge_first=%0d", $time, edge_first_o);
        failed = 1'b1;
      end else begin
        e = seg_expected.pop_front();
        if (edge_first_o !== e.edge_a || frac_first_o !== e.frac_a ||
            edge_second_o !== e.edge_b || frac_second_o !== e.frac_b ||
            last_segment_o !== e.last) begin
          $display("%0t mismatch exp %0d/%0d %0d/%0d last %0b act %0d/%0d %0d/%0d last %0b",
                   $time, e.edge_a, e.frac_a, e.edge_b, e.frac_b, e.last,
                   edge_first_o, frac_first_o, edge_second_o, frac_second_o,
                   last_segment_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Start stays high between back-to-back cells; drop it only while idling.
  task automatic send_cell(logic [ELEV_W-1:0] sw, se, ne, nw, logic vd,
                           logic [ELEV_W-1:0] lv, logic [POS_W-1:0] r, c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    corner_sw_i <= sw; corner_se_i <= se; corner_ne_i <= ne; corner_nw_i <= nw;
    cell_void_i <= vd; contour_level_i <= lv; cell_row_i <= r; cell_col_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_segments(sw, se, ne, nw, vd, lv, r, c);
  endtask

  task automatic drain_segments();
    start <= 1'b0;
    while (seg_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(logic [GW_W-1:0] w);
    drain_segments();
    cfg_valid <= 1'b1;
    cfg_data_i <= w;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    width_model = w;
  endtask

  function automatic logic [ELEV_W-1:0] near_level(logic [ELEV_W-1:0] lv, int unsigned span);
    return lv + ELEV_W'($urandom_range(2 * span) - span);
  endfunction

  task automatic test_directed();
    logic [ELEV_W-1:0] mx, mn;
    mx = 24'h7FFFFF;
    mn = 24'h800000;
    for (int code = 0; code < 16; code++)
      send_cell(code[0] ? 24'd100 : 24'd0, code[1] ? 24'd90 : 24'd10,
                code[2] ? 24'd70 : 24'd20, code[3] ? 24'd55 : 24'd5, 1'b0, 24'd30,
                POS_W'(code), POS_W'(2 * code));
    // saddles with the centre above and below, corners equal to the level
    send_cell(24'd100, 24'd0, 24'd100, 24'd0, 1'b0, 24'd40, 12'd1, 12'd1);
    send_cell(24'd100, 24'd0, 24'd100, 24'd0, 1'b0, 24'd60, 12'd1, 12'd1);
    send_cell(24'd0, 24'd100, 24'd0, 24'd100, 1'b0, 24'd50, 12'd3, 12'd4);
    send_cell(24'd50, 24'd51, 24'd50, 24'd50, 1'b0, 24'd50, 12'd0, 12'd0);
    send_cell(mx, mn, mx, mn, 1'b0, mn, 12'd4094, 12'd4094);
    send_cell(mn, mx, mn, mx, 1'b0, mx - 1, 12'd4095, 12'd4095);
    send_cell(mx, mx, mn, mn, 1'b0, 24'd0, 12'd4094, 12'd0);
    send_cell(mx, 24'd0, 24'd0, 24'd0, 1'b1, 24'd0, 12'd5, 12'd5);
    send_cell(24'd3, 24'd0, 24'd0, 24'd0, 1'b0, 24'd1, 12'd7, 12'd9);
  endtask

  task automatic test_random(int unsigned count);
    logic [ELEV_W-1:0] lv;
    logic [ELEV_W-1:0] cn[4];
    int unsigned span;
    for (int unsigned i = 0; i < count; i++) begin
      lv = $urandom;
      span = ($urandom_range(3) == 0) ? 24'h7FFFFF : (1 << $urandom_range(12));
      foreach (cn[k]) cn[k] = ($urandom_range(9) == 0) ? ELEV_W'($urandom) : near_level(lv, span);
      if ($urandom_range(15) == 0) cn[$urandom_range(3)] = lv;
      send_cell(cn[0], cn[1], cn[2], cn[3], $urandom_range(19) == 0, lv,
                $urandom, $urandom);
    end
  endtask

  task automatic test_idle_phases(int unsigned per_phase);
    idle_pct = 0;  test_random(per_phase);
    idle_pct = 85; test_random(per_phase / 4);
    idle_pct = 6;  test_random(per_phase);
    idle_pct = 0;
  endtask

  task automatic test_widths();
    logic [GW_W-1:0] w[6] = '{13'd2, 13'd8191, 13'd0, 13'd1, 13'd4096, 13'd777};
    foreach (w[k]) begin
      write_width(w[k]);
      test_random(60);
    end
    write_width(GW_W'($urandom));
    test_random(60);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_phases(400);
    test_widths();
    drain_segments();
    if (!failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
